### rtl/core/tme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_pkg
// shared types and constants of the target motion extrapolator
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int CoordW = 16;
  localparam int DistW  = 21;
  localparam int OutW   = 19;
  localparam int SqW    = 34;
  localparam int DiffW  = 17;

  localparam logic [0:0] ModePush    = 1'b0;
  localparam logic [0:0] ModePredict = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT0,
    ST_SQRT1,
    ST_PD,
    ST_DIVX,
    ST_DIVY,
    ST_DONE,
    ST_HOLD
  } tme_state_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic load;
    logic sqrt_start;
    logic sqrt_sel;
    logic calc_pd;
    logic div_start;
    logic div_sel;
    logic finish;
  } tme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic predict_on;
    logic zero_move;
    logic unit_busy;
  } tme_sts_t;

endpackage

### rtl/core/tme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_ctrl
// sequencer that steps the datapath through one transaction
// ----------------------------------------------------------------------------
module tme_ctrl
  import tme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_mode,
  input  logic     out_free,
  input  tme_sts_t sts,
  output logic     busy,
  output tme_cmd_t cmd
);

  tme_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          if (in_mode == ModePush) cmd.push = 1'b1;
          else begin
            cmd.load  = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (!sts.predict_on) state_nxt = ST_DONE;
        else begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT0;
        end
      end
      ST_SQRT0: begin
        if (!sts.unit_busy) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel   = 1'b1;
          state_nxt      = ST_SQRT1;
        end
      end
      ST_SQRT1: if (!sts.unit_busy) state_nxt = ST_PD;
      ST_PD: begin
        cmd.calc_pd = 1'b1;
        if (sts.zero_move) state_nxt = ST_DONE;
        else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (!sts.unit_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = ST_DIVY;
        end
      end
      ST_DIVY: if (!sts.unit_busy) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/tme_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tme_dp
// point ring, shared iterative square root / divider, distance and output
// ----------------------------------------------------------------------------
module tme_dp
  import tme_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tme_cmd_t                 cmd,
  input  logic [CoordW-1:0]        in_x,
  input  logic [CoordW-1:0]        in_y,
  input  logic [15:0]              in_run,
  input  logic [9:0]               in_rate,
  output tme_sts_t                 sts,
  output logic signed [OutW-1:0]   res_x,
  output logic signed [OutW-1:0]   res_y,
  output logic                     res_valid
);

  localparam int SlotW = $clog2(RING_DEPTH);
  localparam int NumW  = DistW + DiffW;   // pd * delta
  localparam int SqStp = SqW / 2;

  // ring with per-entry valid bits (unwritten entries read zero)
  logic [2*CoordW-1:0]   ring_r [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [SlotW-1:0]      slot_r;

  function automatic logic [SlotW-1:0] back(input logic [SlotW-1:0] s, input int k);
    logic [SlotW:0] t;
    t = {1'b0, s} + (SlotW+1)'(RING_DEPTH - k);
    if (t >= (SlotW+1)'(RING_DEPTH)) t = t - (SlotW+1)'(RING_DEPTH);
    return t[SlotW-1:0];
  endfunction

  function automatic logic [DiffW-2:0] adiff(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      slot_r <= '0;
    end else if (cmd.push) begin
      vld_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == SlotW'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) ring_r[slot_r] <= {in_y, in_x};
  end

  // loaded points
  logic [2*CoordW-1:0] p0_r, p1_r, p3_r, p4_r;
  logic                on_r, rate0_r;
  logic [SlotW-1:0]    i0, i1, i3, i4;

  assign i0 = back(slot_r, 1);
  assign i1 = back(slot_r, 2);
  assign i3 = back(slot_r, 4);
  assign i4 = back(slot_r, 5);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p0_r    <= vld_r[i0] ? ring_r[i0] : '0;
      p1_r    <= vld_r[i1] ? ring_r[i1] : '0;
      p3_r    <= vld_r[i3] ? ring_r[i3] : '0;
      p4_r    <= vld_r[i4] ? ring_r[i4] : '0;
      on_r    <= in_run > 16'(RING_DEPTH);
      rate0_r <= in_rate == '0;
    end
  end

  // squared step lengths, one multiplier pass per axis product, registered
  logic [DiffW-2:0] ax, ay;
  logic [SqW-1:0]   sq_in;
  assign ax = cmd.sqrt_sel ? adiff(p3_r[15:0], p4_r[15:0])  : adiff(p0_r[15:0], p1_r[15:0]);
  assign ay = cmd.sqrt_sel ? adiff(p3_r[31:16], p4_r[31:16]) : adiff(p0_r[31:16], p1_r[31:16]);
  assign sq_in = SqW'(ax * ax) + SqW'(ay * ay);

  // shared iterative unit: restoring root (2 bits/step) or divide (1 bit/step)
  logic             is_div_r;
  logic [5:0]       cnt_r;
  logic [SqW-1:0]   rem_r;
  logic [NumW-1:0]  num_r;
  logic [DistW-1:0] dvs_r;
  logic [NumW-1:0]  q_r;
  logic [SqW+1:0]   rtrial;
  logic [NumW:0]    drem;
  logic [NumW:0]    dtrial;
  logic [DistW-1:0] d0_r, d1_r, pd_r, prev_r;
  logic [SqW-1:0]   sq_r;
  logic             dsel_r;
  logic [DistW-1:0] root_q;

  assign root_q = q_r[DistW-1:0];
  assign rtrial = {rem_r, sq_r[SqW-1 -: 2]} - {root_q, 2'b01};
  assign drem   = {(NumW-SqW)'(0), rem_r, num_r[NumW-1]};
  assign dtrial = drem - (NumW+1)'(dvs_r);

  // offset numerator: pd * delta + d0/2, formed in the first divide cycle
  logic [DiffW-2:0] dl;
  assign dl = dsel_r ? adiff(p0_r[31:16], p1_r[31:16]) : adiff(p0_r[15:0], p1_r[15:0]);
  logic [NumW-1:0]  qx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.sqrt_start) begin
      cnt_r    <= 6'(SqStp);
      is_div_r <= 1'b0;
      sq_r     <= sq_in;
      rem_r    <= '0;
      q_r      <= '0;
      dsel_r   <= cmd.sqrt_sel;
      if (cmd.sqrt_sel) d0_r <= root_q;
    end else if (cmd.div_start) begin
      cnt_r    <= 6'(NumW + 1);
      is_div_r <= 1'b1;
      dvs_r    <= d0_r;
      rem_r    <= '0;
      q_r      <= '0;
      dsel_r   <= cmd.div_sel;
      if (cmd.div_sel) qx_r <= q_r;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (!is_div_r) begin
        sq_r <= sq_r << 2;
        if (!rtrial[SqW+1]) begin
          rem_r <= rtrial[SqW-1:0];
          q_r   <= {q_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SqW-3:0], sq_r[SqW-1 -: 2]};
          q_r   <= {q_r[NumW-2:0], 1'b0};
        end
      end else if (cnt_r == 6'(NumW + 1)) begin
        num_r <= NumW'(pd_r * dl) + NumW'(d0_r >> 1);
      end else begin
        num_r <= num_r << 1;
        if (!dtrial[NumW]) begin
          rem_r <= SqW'(dtrial[NumW-1:0]);
          q_r   <= {q_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= SqW'(drem[NumW-1:0]);
          q_r   <= {q_r[NumW-2:0], 1'b0};
        end
      end
    end
  end

  // second root result is d1 (sqrt_sel run); first is captured as d0 at next start
  logic [DistW-1:0] dd, pd_raw, pd_nxt_w;
  assign d1_r = root_q;
  assign dd = (d0_r >= d1_r) ? d0_r - d1_r : d1_r - d0_r;

  always_comb begin
    logic [DistW+5:0] t;
    t = (DistW+6)'(9) * d0_r + (DistW+6)'(18) * dd;
    pd_raw   = DistW'(t >> 1);
    pd_nxt_w = pd_raw;
    if (prev_r != '0) begin
      if (prev_r > pd_raw && prev_r - pd_raw > DistW'(32)) pd_nxt_w = prev_r - DistW'(16);
      else if (pd_raw > prev_r && pd_raw - prev_r > DistW'(32))
        pd_nxt_w = prev_r + DistW'(16);
    end
  end

  logic zero_move;
  assign zero_move = rate0_r || (d0_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) prev_r <= '0;
    else if (cmd.calc_pd) prev_r <= zero_move ? '0 : pd_nxt_w;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_pd) pd_r <= pd_nxt_w;
  end

  assign sts.predict_on = on_r;
  assign sts.zero_move  = zero_move;
  assign sts.unit_busy  = cnt_r != '0;

  // saturated result assembly
  function automatic logic signed [OutW-1:0] mv(input logic [CoordW-1:0] nw,
                                                input logic [CoordW-1:0] od,
                                                input logic [NumW-1:0] off);
    logic signed [NumW+1:0] v;
    if (nw >= od) v = $signed({2'b0, NumW'(nw)}) + $signed({2'b0, off});
    else          v = $signed({2'b0, NumW'(nw)}) - $signed({2'b0, off});
    if (v > (NumW+2)'(262143))       return OutW'(262143);
    if (v < -(NumW+2)'(262144))      return OutW'(-262144);
    return v[OutW-1:0];
  endfunction

  logic mv_r;
  always_ff @(posedge clk) begin
    if (cmd.calc_pd) mv_r <= !zero_move;
  end

  assign res_valid = on_r;
  assign res_x = !on_r ? '0 : !mv_r ? OutW'(p0_r[15:0]) : mv(p0_r[15:0], p1_r[15:0], qx_r);
  assign res_y = !on_r ? '0 : !mv_r ? OutW'(p0_r[31:16]) : mv(p0_r[31:16], p1_r[31:16], q_r);

  logic unused;
  assign unused = cmd.finish;

endmodule

### rtl/core/target_motion_extrapolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// target_motion_extrapolator_core
// keeps recent target centres and predicts the next one at end of frame
// ----------------------------------------------------------------------------
// in_ channel: mode in in_tuser, point/run/rate in in_tdata.
// a push transaction (mode 0) is taken without leaving idle and gives no result.
// an end-of-frame transaction (mode 1) gives exactly one out_ transaction.
// an accepted prediction passes LOAD, DONE and HOLD before the result is
// registered when the run count is at or below the ring depth; it also runs
// two 17-step roots when the frame rate or the newest step is zero, and
// otherwise two 17-step roots and two 38-step divides in the single shared
// iterative unit. one transaction is worked at a time; in_tready is low while
// busy and is high again once the result is registered.
// the result sits in an output register; a stalled receiver holds the block.
// reset clears the ring valid bits, write slot and previous distance.
// ----------------------------------------------------------------------------
module target_motion_extrapolator_core
  import tme_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // point_x, point_y, run_count, frame_rate, pad
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // predicted_x, predicted_y, pad
  output logic        out_tuser   // prediction_valid
);

  tme_cmd_t cmd;
  tme_sts_t sts;
  logic busy, in_fire;
  logic signed [OutW-1:0] rx, ry;
  logic rv;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  tme_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(in_tuser),
    .out_free(!out_tvalid || out_tready), .sts(sts), .busy(busy), .cmd(cmd)
  );

  tme_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_x(in_tdata[15:0]), .in_y(in_tdata[31:16]), .in_run(in_tdata[47:32]),
    .in_rate(in_tdata[57:48]), .sts(sts), .res_x(rx), .res_y(ry), .res_valid(rv)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (cmd.finish) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_tdata <= {2'b0, ry, rx};
      out_tuser <= rv;
    end
  end

  logic unused_in;
  assign unused_in = ^in_tdata[63:58];

  // checks
  a_no_cmd_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sqrt_start && cmd.div_start)) else $error("unit started twice");
  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !busy) else $error("push while busy");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid) else $error("result lost");

endmodule
